// ===== rtl/tms_pkg.sv =====
// Shared types and constants of the tone melody sequencer.
package tms_pkg;

    localparam int TICKS_W   = 13;
    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int DIVISOR_W = 16;
    localparam int GAP_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [TICKS_W-1:0] TICKS_MAX = 13'd8191;
    localparam logic [TICKS_W-1:0] TICKS_MIN = 13'd1;

    localparam logic CMD_NOTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_BUSY = 1'b1;

    // word index of the gap register on the configuration port
    localparam logic REG_GAP_IDX = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TONE = 2'd1,
        PH_REST = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FREQ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 cmd;
        logic [FREQ_W-1:0]    freq_hz;
        logic [DUR_W-1:0]     duration_ms;
        logic                 last_note;
    } in_item_t;

    typedef struct packed {
        logic                 speaker_enable;
        logic [DIVISOR_W-1:0] divisor;
        logic                 divisor_loaded;
        logic [1:0]           phase;
        logic                 note_complete;
        logic                 status;
    } out_item_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        logic     reject;
        logic     tick_dec;
        logic     go_idle;
        logic     load_divisor;
        logic     start_note;
        logic     start_gap;
        logic     out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic cmd_is_tick;
        logic phase_idle;
        logic freq_nonzero;
        logic ticks_gt1;
        logic gap_due;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/tms_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tms_div #(
    parameter int DW = 21,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [VW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg[VW-1:0], quo_reg[DW-1]};
        fits      = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/tms_dp.sv =====
// Datapath: note state, tick counter, divisor, frequency divider and result register.
module tms_dp #(
    parameter int PIT_CLOCK_HZ = 1193182,
    parameter int TICK_MS      = 10,
    parameter int DIV_W        = 21
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tms_pkg::in_item_t          in_data,
    input  logic [tms_pkg::GAP_W-1:0]  gap_ms,
    input  tms_pkg::ctl_cmd_t          cmd,
    output tms_pkg::dp_stat_t          stat,
    output tms_pkg::out_item_t         out_data
);
    import tms_pkg::*;

    localparam logic [DIV_W-1:0] PIT_DIVIDEND = DIV_W'(PIT_CLOCK_HZ);

    // ceil(ms / TICK_MS) as (ms + TICK_MS - 1) * RECIP >> TICK_SH, exact for MS_W-bit operands
    localparam int     MS_W       = DUR_W + 1;
    localparam int     TICK_SH    = MS_W + $clog2(TICK_MS);
    localparam int     RECIP_W    = MS_W + 2;
    localparam int     PROD_W     = MS_W + RECIP_W;
    localparam longint RECIP_FULL = ((longint'(1) << TICK_SH) + longint'(TICK_MS - 1))
                                    / longint'(TICK_MS);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
    localparam logic [MS_W-1:0]    MS_BIAS = MS_W'(TICK_MS - 1);

    phase_t             phase_reg, phase_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic               final_reg, final_next;
    in_item_t           item_reg;
    logic               loaded_reg, loaded_next;
    logic               complete_reg, complete_next;
    logic               status_reg, status_next;
    out_item_t          out_reg;

    logic [DIV_W-1:0]     quotient;
    logic                 div_done;
    logic [DUR_W-1:0]     ms_src;
    logic [MS_W-1:0]      ms_biased;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    ms_quot;
    logic [TICKS_W-1:0]   sat_ticks;

    tms_div #(
        .DW (DIV_W),
        .VW (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (PIT_DIVIDEND),
        .divisor  (item_reg.freq_hz),
        .done     (div_done),
        .quotient (quotient)
    );

    // convert ms to ticks and clamp the count to [1, TICKS_MAX]
    always_comb
    begin
        ms_src    = cmd.start_gap ? gap_ms : item_reg.duration_ms;
        ms_biased = MS_W'(ms_src) + MS_BIAS;
        prod      = PROD_W'(ms_biased) * PROD_W'(RECIP);
        ms_quot   = prod >> TICK_SH;
        if (ms_quot > PROD_W'(TICKS_MAX))
            sat_ticks = TICKS_MAX;
        else if (ms_quot == '0)
            sat_ticks = TICKS_MIN;
        else
            sat_ticks = ms_quot[TICKS_W-1:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        divisor_next  = divisor_reg;
        final_next    = final_reg;
        loaded_next   = loaded_reg;
        complete_next = complete_reg;
        status_next   = status_reg;
        if (cmd.capture)
        begin
            loaded_next   = 1'b0;
            complete_next = 1'b0;
            status_next   = STAT_OK;
        end
        if (cmd.reject)
            status_next = STAT_BUSY;
        if (cmd.tick_dec)
            ticks_next = ticks_reg - TICKS_W'(1);
        if (cmd.go_idle)
        begin
            phase_next    = PH_IDLE;
            ticks_next    = '0;
            complete_next = 1'b1;
        end
        if (cmd.load_divisor)
        begin
            divisor_next = quotient[DIVISOR_W-1:0];
            loaded_next  = 1'b1;
        end
        if (cmd.start_note)
        begin
            phase_next = (item_reg.freq_hz != '0) ? PH_TONE : PH_REST;
            ticks_next = sat_ticks;
            final_next = item_reg.last_note;
        end
        if (cmd.start_gap)
        begin
            phase_next = PH_GAP;
            ticks_next = sat_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ticks_reg   <= '0;
            divisor_reg <= '0;
            final_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            divisor_reg <= divisor_next;
            final_reg   <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        loaded_reg   <= loaded_next;
        complete_reg <= complete_next;
        status_reg   <= status_next;
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.out_load)
        begin
            out_reg.speaker_enable <= (phase_reg == PH_TONE);
            out_reg.divisor        <= divisor_reg;
            out_reg.divisor_loaded <= loaded_reg;
            out_reg.phase          <= phase_reg;
            out_reg.note_complete  <= complete_reg;
            out_reg.status         <= status_reg;
        end
    end

    always_comb
    begin
        stat.cmd_is_tick  = (item_reg.cmd == CMD_TICK);
        stat.phase_idle   = (phase_reg == PH_IDLE);
        stat.freq_nonzero = (item_reg.freq_hz != '0);
        stat.ticks_gt1    = (ticks_reg > TICKS_W'(1));
        stat.gap_due      = (phase_reg != PH_GAP) && (gap_ms != '0) && !final_reg;
        stat.div_done     = div_done;
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/tms_ctrl.sv =====
// Controller: sequences capture, division, state updates and result hand-off.
module tms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tms_pkg::dp_stat_t  stat,
    output tms_pkg::ctl_cmd_t  cmd
);
    import tms_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (!stat.cmd_is_tick && stat.phase_idle && stat.freq_nonzero)
                    state_next = ST_FREQ;
                else
                    state_next = ST_DONE;
            end
            ST_FREQ:
                if (stat.div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EVAL:
            begin
                if (!stat.cmd_is_tick)
                begin
                    if (!stat.phase_idle)
                        cmd.reject = 1'b1;
                    else if (stat.freq_nonzero)
                        cmd.div_start = 1'b1;
                    else
                        cmd.start_note = 1'b1;
                end
                else if (!stat.phase_idle)
                begin
                    if (stat.ticks_gt1)
                        cmd.tick_dec = 1'b1;
                    else if (stat.gap_due)
                        cmd.start_gap = 1'b1;
                    else
                        cmd.go_idle = 1'b1;
                end
            end
            ST_FREQ:
            begin
                // load the divisor and start the tone together
                cmd.load_divisor = stat.div_done;
                cmd.start_note   = stat.div_done;
            end
            ST_DONE:
                cmd.out_load = slot_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/tone_melody_sequencer.sv =====
// Top level of the tone melody sequencer: configuration port, controller and datapath.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_ready  in_data   (cmd, freq_hz, duration_ms, last_note)
//   out       source     out_valid/out_ready  out_data  (speaker_enable .. status)
//   apb       slave      psel/penable/pready  paddr, pwdata, prdata (gap_ms at 0x0)
//
// One item at a time. A tick, a rest or a busy note passes through evaluation
// and hand-off; a tone also runs the restoring divider, DIV_W bits wide
// (21 bits with the default clock). Tick counts come from a constant reciprocal
// multiply. The next item is taken while a result waits.
// Reset is asynchronous, active low; it clears the phase, counters, divisor
// and gap register. A stalled result holds the block in its hand-off state.
module tone_melody_sequencer #(
    parameter int PIT_CLOCK_HZ = 1193182,
    parameter int TICK_MS      = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tms_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tms_pkg::out_item_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tms_pkg::APB_AW-1:0]  paddr,
    input  logic [tms_pkg::APB_DW-1:0]  pwdata,
    output logic [tms_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import tms_pkg::*;

    localparam int DIV_W = $clog2(PIT_CLOCK_HZ + 1);

    logic [GAP_W-1:0] gap_ms_reg, gap_ms_next;
    logic             gap_sel;
    ctl_cmd_t         cmd;
    dp_stat_t         stat;

    assign gap_sel = (paddr[APB_AW-1] == REG_GAP_IDX);
    assign pready  = 1'b1;

    always_comb
    begin
        gap_ms_next = gap_ms_reg;
        if (psel && penable && pwrite && gap_sel)
            gap_ms_next = pwdata[GAP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_ms_reg <= '0;
        else
            gap_ms_reg <= gap_ms_next;
    end

    assign prdata = gap_sel ? APB_DW'(gap_ms_reg) : '0;

    tms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tms_dp #(
        .PIT_CLOCK_HZ (PIT_CLOCK_HZ),
        .TICK_MS      (TICK_MS),
        .DIV_W        (DIV_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .gap_ms   (gap_ms_reg),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    // an accepted transaction occupies the block for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_speaker_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.speaker_enable == (out_data.phase == PH_TONE))
        else $error("speaker enable disagrees with phase");

    a_reject_changes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> !out_data.divisor_loaded && !out_data.note_complete)
        else $error("rejected note reported a state change");

    a_complete_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.note_complete |-> out_data.phase == PH_IDLE)
        else $error("note completed but phase not idle");

endmodule

// ===== sim/tms_checker.sv =====
// Checker for the tone melody sequencer: tracks the melody state and compares every result.
module tms_checker
    import tms_pkg::*;
#(
    parameter int PIT_CLOCK_HZ = 1193182,
    parameter int TICK_MS      = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    input  logic [APB_DW-1:0]  prdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending,
    output logic               melody_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;
    localparam logic [APB_AW-1:0] GAP_ADDR = {REG_GAP_IDX, 2'b00};

    phase_t               mel_phase   = PH_IDLE;
    logic [TICKS_W-1:0]   mel_ticks   = '0;
    logic [DIVISOR_W-1:0] mel_divisor = '0;
    logic                 mel_last    = 1'b0;
    logic [GAP_W-1:0]     gap_ms      = '0;
    out_item_t            awaited_out[$];
    int                   reported    = 0;

    initial begin
        errors  = 0;
        pending = 0;
    end

    assign melody_busy = (mel_phase != PH_IDLE);

    function automatic logic [TICKS_W-1:0] ms_to_tick_count(input logic [15:0] ms);
        int unsigned t;
        t = ({16'b0, ms} + TICK_MS - 1) / TICK_MS;
        if (t == 0)
            t = 1;
        if (t > TICKS_MAX)
            t = 32'(TICKS_MAX);
        return t[TICKS_W-1:0];
    endfunction

    // Apply one transaction to the melody state and return the result it should produce.
    function automatic out_item_t advance_melody(input in_item_t it);
        out_item_t   r;
        int unsigned quotient;
        r = '0;
        r.status = STAT_OK;
        if (it.cmd == CMD_NOTE) begin
            if (mel_phase != PH_IDLE) begin
                r.status = STAT_BUSY;
            end
            else begin
                if (it.freq_hz != '0) begin
                    quotient         = 32'(PIT_CLOCK_HZ) / {16'b0, it.freq_hz};
                    mel_divisor      = quotient[DIVISOR_W-1:0];
                    r.divisor_loaded = 1'b1;
                    mel_phase        = PH_TONE;
                end
                else begin
                    mel_phase = PH_REST;
                end
                mel_ticks = ms_to_tick_count(it.duration_ms);
                mel_last  = it.last_note;
            end
        end
        else if (mel_phase != PH_IDLE) begin
            if (mel_ticks > 1) begin
                mel_ticks = mel_ticks - 1'b1;
            end
            else begin
                mel_ticks = '0;
                // a finished tone or rest rolls into the gap unless it was the last note or the gap is zero
                if (mel_phase != PH_GAP && gap_ms != '0 && !mel_last) begin
                    mel_phase = PH_GAP;
                    mel_ticks = ms_to_tick_count(gap_ms);
                end
                else begin
                    mel_phase       = PH_IDLE;
                    r.note_complete = 1'b1;
                end
            end
        end
        r.speaker_enable = (mel_phase == PH_TONE);
        r.divisor        = mel_divisor;
        r.phase          = mel_phase;
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        errors = errors + 1;
        if (reported < REPORT_MAX) begin
            reported = reported + 1;
            $display("%0t checker: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t want;
        logic      differs;
        if (!rst_n) begin
            mel_phase   = PH_IDLE;
            mel_ticks   = '0;
            mel_divisor = '0;
            mel_last    = 1'b0;
            gap_ms      = '0;
            awaited_out.delete();
        end
        else begin
            // compare before pushing so a result never meets its own transaction
            if (out_valid && out_ready) begin
                if (awaited_out.size() == 0) begin
                    flag_failure($sformatf("unexpected result %h", out_data));
                end
                else begin
                    want    = awaited_out.pop_front();
                    differs = (out_data.speaker_enable !== want.speaker_enable)
                           || (out_data.divisor        !== want.divisor)
                           || (out_data.divisor_loaded !== want.divisor_loaded)
                           || (out_data.phase          !== want.phase)
                           || (out_data.note_complete  !== want.note_complete)
                           || (out_data.status         !== want.status);
                    if (differs)
                        flag_failure($sformatf(
                            {"mismatch exp spk=%b div=%h ld=%b ph=%0d done=%b st=%b",
                             " got spk=%b div=%h ld=%b ph=%0d done=%b st=%b"},
                            want.speaker_enable, want.divisor, want.divisor_loaded,
                            want.phase, want.note_complete, want.status,
                            out_data.speaker_enable, out_data.divisor,
                            out_data.divisor_loaded, out_data.phase,
                            out_data.note_complete, out_data.status));
                end
            end
            if (in_valid && in_ready)
                awaited_out.push_back(advance_melody(in_data));
            if (psel && penable && pready && paddr == GAP_ADDR) begin
                if (pwrite)
                    gap_ms = pwdata[GAP_W-1:0];
                else if (prdata !== APB_DW'(gap_ms))
                    flag_failure($sformatf("gap read exp %h got %h",
                                           APB_DW'(gap_ms), prdata));
            end
        end
        pending = awaited_out.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top: stimulus, register programming and verdict for the tone melody sequencer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tms_pkg::*;

    localparam int CLOCK_HZ      = 1193182;
    localparam int TICK_LEN_MS   = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 36;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASES        = 6;
    localparam int FINAL_TICKS   = 40;
    localparam logic [APB_AW-1:0] GAP_ADDR = {REG_GAP_IDX, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 errors;
    int                 pending;
    logic               melody_busy;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    int                 counted = 0;
    int                 cycle_count = 0;
    logic [GAP_W-1:0]   gap_plan [PHASES] = '{16'd0, 16'd10, 16'd1, 16'd30, 16'd57, 16'd100};

    always #2 clk = ~clk;

    tone_melody_sequencer #(
        .PIT_CLOCK_HZ (CLOCK_HZ),
        .TICK_MS      (TICK_LEN_MS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tms_checker #(
        .PIT_CLOCK_HZ (CLOCK_HZ),
        .TICK_MS      (TICK_LEN_MS)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .pending     (pending),
        .melody_busy (melody_busy)
    );

    function automatic in_item_t make_item(input logic cmd, input logic [15:0] freq,
                                           input logic [15:0] dur, input logic last);
        in_item_t it;
        it.cmd         = cmd;
        it.freq_hz     = freq;
        it.duration_ms = dur;
        it.last_note   = last;
        return it;
    endfunction

    // All tasks below are entered and left at a falling edge.
    task automatic send_item(input in_item_t it);
        counted = counted + 1;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        in_valid = 1'b1;
        in_data  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_note(input logic [15:0] freq, input logic [15:0] dur,
                             input logic last);
        send_item(make_item(CMD_NOTE, freq, dur, last));
    endtask

    task automatic send_tick();
        send_item(make_item(CMD_TICK, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_busy_note();
        send_note(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold the input side until every result is back and the block has settled.
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [GAP_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = GAP_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_gap(input logic [GAP_W-1:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    // One musical phrase: mostly a note ticked through to its end, sometimes noise
    // or a phrase cut short.
    task automatic run_phrase();
        int          pick;
        int          limit;
        int          n;
        logic [15:0] freq;
        logic [15:0] dur;
        logic        cmd;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 6)) begin
                cmd = 1'($urandom_range(0, 1));
                dur = melody_busy ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 300));
                send_item(make_item(cmd, 16'($urandom_range(0, 65535)), dur,
                                    1'($urandom_range(0, 1))));
            end
        end
        else begin
            n = $urandom_range(0, 99);
            if (n < 20)
                freq = '0;
            else if (n < 40)
                freq = 16'($urandom_range(1, 40));
            else
                freq = 16'($urandom_range(0, 65535));
            n = $urandom_range(0, 99);
            if (n < 85)
                dur = 16'($urandom_range(0, 60));
            else if (n < 97)
                dur = 16'($urandom_range(61, 600));
            else
                dur = 16'($urandom_range(601, 2000));
            send_note(freq, dur, 1'($urandom_range(0, 1)));
            limit = (pick < 18) ? $urandom_range(0, 3) : 32'h7fff_ffff;
            n = 0;
            while (melody_busy && n < limit) begin
                if ($urandom_range(0, 9) == 0)
                    send_busy_note();
                send_tick();
                n = n + 1;
            end
            repeat ($urandom_range(0, 2)) send_tick();
        end
    endtask

    // Receiver: random backpressure, a calm stretch, and one long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset value of the gap register, then the corner cases with no gap
        apb_access(1'b0, '0);
        send_tick();
        send_note(16'd1, 16'd0, 1'b0);
        send_note(16'hFFFF, 16'hFFFF, 1'b1);
        send_tick();
        send_note(16'hFFFF, 16'd10, 1'b1);
        send_tick();
        send_note(16'd0, 16'd11, 1'b0);
        send_tick();
        send_tick();
        send_note(16'd18, 16'd1, 1'b0);
        send_tick();
        drain();

        // with a three-tick gap: tone into gap, last note skips it, rest into gap
        program_gap(16'd25);
        send_note(16'd440, 16'd20, 1'b0);
        send_tick();
        send_note(16'd0, 16'd0, 1'b0);
        repeat (4) send_tick();
        send_note(16'd1000, 16'd9, 1'b1);
        send_tick();
        send_note(16'd0, 16'd25, 1'b0);
        repeat (6) send_tick();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            program_gap(gap_plan[p]);
            if (p == 1)
                hold_req = 1'b1;
            calm = (p == 3);
            while (counted < RANDOM_ITEMS * (p + 1) / PHASES)
                run_phrase();
            drain();
        end

        // a short tone into the longest gap, the start of it sent back to back
        calm = 1'b1;
        program_gap(16'hFFFF);
        send_note(16'($urandom_range(1, 65535)), 16'd10, 1'b0);
        send_tick();
        repeat (FINAL_TICKS) send_tick();
        send_busy_note();
        drain();
        calm = 1'b0;

        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
